FILE: sv/bhgt_pkg.sv
// Package: shared types and constants for the byte histogram gap tracker.
`default_nettype none
package bhgt_pkg;

    localparam int POS_W      = 32;   // width of positions, gaps and counts
    localparam int NUM_VALUES = 256;  // one entry per byte value
    localparam int IDX_W      = $clog2(NUM_VALUES);
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 16;   // two byte fields
    localparam int OUT_DATA_W = 4 * POS_W;

    localparam logic [POS_W-1:0] TOTAL_LIMIT = 32'hFFFF_FFFF;

    // Operation carried on the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_FEED  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // One statistics entry as stored in the memory
    typedef struct packed {
        logic [POS_W-1:0] occurrence;
        logic [POS_W-1:0] gap_end;
        logic [POS_W-1:0] largest_gap;
        logic [POS_W-1:0] last_seen;
    } t_entry;

endpackage
`default_nettype wire

FILE: sv/byte_histogram_gap_tracker_top.sv
// Top level: byte histogram with per-value largest-gap tracking.
`default_nettype none
// One item per clock cycle for any mix of feeds, reads and clears while the
// output register does not hold back a read. For each item the entry is read
// from a single 256 x 128-bit memory in the cycle the beat is accepted and
// modified and written back in the next one. A feed or read that directly
// follows a feed of the same byte value gets the fresh entry by forwarding,
// so repeated values cost no bubble. A read result passes through stage 1
// into an output register and is held there; the input stalls only when that
// register is full, not taken, and another read is ready to leave. A clear
// takes effect at once through per-entry valid flags, with no sweep. Position
// counting saturates at 4294967295 bytes; feeds after that are dropped.
module byte_histogram_gap_tracker_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: byte_value [7:0], entry_index [15:8]
    input  wire  [bhgt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: operation [1:0]
    input  wire  [bhgt_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // tdata: entry_count [31:0], entry_gap_end [63:32],
    //        entry_largest_gap [95:64], total_bytes [127:96]
    output logic [bhgt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bhgt_pkg::*;

    // Statistics memory and its valid flags
    t_entry               r_mem [NUM_VALUES];
    logic [NUM_VALUES-1:0] r_vld;

    // Stage 1 (modify/write) registers
    logic             r_s1_vld;
    t_op              r_s1_op;
    logic [IDX_W-1:0] r_s1_addr;
    t_entry           r_rdata;
    logic             r_rvld;
    logic             r_fwd_hit;
    t_entry           r_fwd_data;

    // Position counter and output register
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic             in_acc;
    logic [IDX_W-1:0] in_addr;
    t_op              in_op;
    logic             s1_go;
    logic             s1_is_read;
    t_entry           cur;
    t_entry           wr_data;
    logic             wr_en;
    logic             clr_en;
    logic [POS_W-1:0] gap;

    // Input decode
    assign in_op   = t_op'(s_axis_tuser);
    assign in_addr = (in_op == OP_READ) ? s_axis_tdata[15:8] : s_axis_tdata[7:0];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // Stage 1 advances unless it holds a read that cannot enter the output register
    assign s1_is_read    = (r_s1_op == OP_READ);
    assign s1_go         = r_s1_vld && (!s1_is_read || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_go;

    // Current entry: forwarded write, else memory data gated by its valid flag
    always_comb begin
        if (r_fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_rvld) begin
            cur = r_rdata;
        end else begin
            cur = '0;
        end
    end

    // Modify: feed update and clear
    always_comb begin
        wr_en   = 1'b0;
        clr_en  = 1'b0;
        wr_data = cur;
        n_pos   = r_pos;
        gap     = r_pos - cur.last_seen;
        case (r_s1_op)
            OP_FEED: begin
                if (s1_go && (r_pos != TOTAL_LIMIT)) begin
                    wr_en = 1'b1;
                    if (gap > cur.largest_gap) begin
                        wr_data.largest_gap = gap;
                        wr_data.gap_end     = r_pos;
                    end
                    wr_data.last_seen  = r_pos;
                    wr_data.occurrence = cur.occurrence + 1'b1;
                    n_pos              = r_pos + 1'b1;
                end
            end
            OP_CLEAR: begin
                if (s1_go) begin
                    clr_en = 1'b1;
                    n_pos  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Memory: one write and one registered read per cycle, the read only when a beat is accepted
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_addr] <= wr_data;
        end
        if (in_acc) begin
            r_rdata <= r_mem[in_addr];
        end
    end

    // Valid flags, cleared all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_en) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_s1_addr] <= 1'b1;
        end
    end

    // Stage 1 payload, valid flag sample and forwarding capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= in_op;
            r_s1_addr  <= in_addr;
            r_rvld     <= r_vld[in_addr];
            r_fwd_hit  <= clr_en || (wr_en && (r_s1_addr == in_addr));
            r_fwd_data <= clr_en ? '0 : wr_data;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go && s1_is_read) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (s1_go && s1_is_read) begin
            r_out_data <= {r_pos, cur.largest_gap, cur.gap_end, cur.occurrence};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A clear leaves the position at zero
    a_clear_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_s1_op == OP_CLEAR)) |=> (r_pos == '0))
        else $error("position not zero after clear");

    // A feed below the limit advances the position by one
    a_feed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && (r_s1_op == OP_FEED) && (r_pos != TOTAL_LIMIT))
        |=> (r_pos == $past(r_pos) + 1'b1))
        else $error("feed did not advance position");

    // A read beat reports the position current when it left stage 1
    a_read_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_is_read) |=> (m_axis_tvalid && (m_axis_tdata[127:96] == $past(r_pos))))
        else $error("read beat total mismatch");

    // Position never moves unless stage 1 executes
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_go |=> $stable(r_pos))
        else $error("position changed without an item");
`endif

endmodule
`default_nettype wire
